>>> hw/rtl/ddo_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddo_pkg
// Shared types, constants and the arctangent table of the odometry unit.
// ----------------------------------------------------------------------------
package ddo_pkg;

  localparam int FRAC_BITS_DEF    = 16;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int HT_W             = 20;
  localparam logic [HT_W-1:0] HT_RESET = 20'd2048;

  localparam logic [1:0] ADDR_HT = 2'd0;

  localparam logic [1:0] CMD_SAMPLE = 2'd0;
  localparam logic [1:0] CMD_SET_X  = 2'd1;
  localparam logic [1:0] CMD_SET_Y  = 2'd2;
  localparam logic [1:0] CMD_SET_H  = 2'd3;

  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] right_count;
    logic signed [31:0] left_count;
    logic signed [47:0] set_value;
  } cmd_item_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    case (i)
      5'd0:    atan_turn = 32'd536870912;
      5'd1:    atan_turn = 32'd316933406;
      5'd2:    atan_turn = 32'd167458907;
      5'd3:    atan_turn = 32'd85004756;
      5'd4:    atan_turn = 32'd42667331;
      5'd5:    atan_turn = 32'd21354465;
      5'd6:    atan_turn = 32'd10679838;
      5'd7:    atan_turn = 32'd5340245;
      5'd8:    atan_turn = 32'd2670163;
      5'd9:    atan_turn = 32'd1335087;
      5'd10:   atan_turn = 32'd667544;
      5'd11:   atan_turn = 32'd333772;
      5'd12:   atan_turn = 32'd166886;
      5'd13:   atan_turn = 32'd83443;
      5'd14:   atan_turn = 32'd41722;
      5'd15:   atan_turn = 32'd20861;
      5'd16:   atan_turn = 32'd10430;
      5'd17:   atan_turn = 32'd5215;
      5'd18:   atan_turn = 32'd2608;
      5'd19:   atan_turn = 32'd1304;
      5'd20:   atan_turn = 32'd652;
      5'd21:   atan_turn = 32'd326;
      5'd22:   atan_turn = 32'd163;
      5'd23:   atan_turn = 32'd81;
      default: atan_turn = 32'd0;
    endcase
  endfunction

endpackage

>>> hw/rtl/differential_drive_odometry_unit.sv
`timescale 1ns / 1ps
// Sample path: a sample beat passes through the queue, the modulo pass and the
// angle division of the divider, the handoff, the CORDIC rotations, the multiply,
// the accumulate and the output register; set commands go to the output register.
// Throughput: one item in the back engine at a time; a new beat is taken only
// once the result register is empty. A two-beat queue holds beats.
// Reset (rst, synchronous): state cleared, half_turn_ticks = 2048.
// ----------------------------------------------------------------------------
// differential_drive_odometry_unit
// Wheel odometry with fixed-point CORDIC position integration.
// ----------------------------------------------------------------------------
module differential_drive_odometry_unit #(
  parameter int FRAC_BITS    = ddo_pkg::FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [1:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  input  logic         s_tvalid,
  output logic         s_tready,
  // command[1:0]
  input  logic [1:0]   s_tuser,
  // right_count[31:0], left_count[63:32], set_value[111:64]
  input  logic [111:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // pos_x[47:0], pos_y[95:48], heading[127:96], travelled[159:128],
  // dist_rate[191:160], angular_speed[223:192]
  output logic [223:0] m_tdata
);

  logic [ddo_pkg::HT_W-1:0] half_turn_ticks;
  ddo_pkg::cmd_item_t in_item;
  ddo_pkg::cmd_item_t q_item;
  logic q_valid;
  logic q_ready;
  logic [47:0] pos_x;
  logic [47:0] pos_y;
  logic [31:0] heading;
  logic [31:0] travelled;
  logic [31:0] dist_rate;
  logic [31:0] angular_speed;

  assign pready = 1'b1;
  assign prdata = (paddr == ddo_pkg::ADDR_HT) ? {12'd0, half_turn_ticks} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_turn_ticks <= ddo_pkg::HT_RESET;
    end else if (psel && penable && pwrite && paddr == ddo_pkg::ADDR_HT) begin
      half_turn_ticks <= pwdata[ddo_pkg::HT_W-1:0];
    end
  end

  assign in_item = {s_tuser, s_tdata[31:0], s_tdata[63:32], s_tdata[111:64]};

  ddo_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  ddo_back #(
    .FRAC_BITS    (FRAC_BITS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .half_turn_ticks (half_turn_ticks),
    .q_valid         (q_valid),
    .q_ready         (q_ready),
    .q_item          (q_item),
    .out_valid       (m_tvalid),
    .out_ready       (m_tready),
    .pos_x           (pos_x),
    .pos_y           (pos_y),
    .heading         (heading),
    .travelled       (travelled),
    .dist_rate       (dist_rate),
    .angular_speed   (angular_speed)
  );

  assign m_tdata = {angular_speed, dist_rate, travelled, heading, pos_y, pos_x};

endmodule

>>> hw/rtl/ddo_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddo_front
// A two-entry queue that decouples the stream from the
// odometry engine.
// ----------------------------------------------------------------------------
module ddo_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  ddo_pkg::cmd_item_t in_item,
  output logic              q_valid,
  input  logic              q_ready,
  output ddo_pkg::cmd_item_t q_item
);

  ddo_pkg::cmd_item_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  logic push;
  logic pop;

  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_item   = mem[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

>>> hw/rtl/ddo_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddo_divider
// Restoring divider, one quotient bit per cycle. First takes a signed modulo
// (mid mod period) in a first pass, then computes the 32-bit binary angle
// floor(r * 2^32 / period) for the reduced 0 <= r < period.
// ----------------------------------------------------------------------------
module ddo_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] mid,
  input  logic [20:0] period,
  output logic        done,
  output logic [31:0] angle
);

  typedef enum logic [1:0] {S_IDLE, S_MOD, S_FRAC} state_t;

  state_t      state;
  logic [5:0]  cnt;
  logic [31:0] mag;
  logic        neg;
  logic [21:0] rem;
  logic [31:0] quo;

  logic [21:0] rem_sh;
  logic [21:0] rem_sub;
  logic        fit;

  always_comb begin
    if (state == S_MOD) begin
      rem_sh = {rem[20:0], mag[31]};
    end else begin
      rem_sh = {rem[20:0], 1'b0};
    end
    rem_sub = rem_sh - {1'b0, period};
    fit     = (rem_sh >= {1'b0, period});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      cnt   <= 6'd0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            neg   <= mid[31];
            mag   <= mid[31] ? (~mid + 32'd1) : mid;
            rem   <= 22'd0;
            cnt   <= 6'd0;
            state <= S_MOD;
          end
        end
        S_MOD: begin
          rem <= fit ? rem_sub : rem_sh;
          mag <= {mag[30:0], 1'b0};
          cnt <= cnt + 6'd1;
          if (cnt == 6'd31) begin
            cnt   <= 6'd0;
            state <= S_FRAC;
          end
        end
        S_FRAC: begin
          if (cnt == 6'd0) begin
            // apply sign of C remainder, then take it into 0..period-1
            if (neg && rem != 22'd0) begin
              rem <= {1'b0, period} - rem;
            end
            cnt <= 6'd1;
          end else begin
            rem <= fit ? rem_sub : rem_sh;
            quo <= {quo[30:0], fit};
            cnt <= cnt + 6'd1;
            if (cnt == 6'd32) begin
              done  <= 1'b1;
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign angle = quo;

endmodule

>>> hw/rtl/ddo_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddo_back
// Odometry engine: state update, angle reduction, iterative CORDIC, scaled
// accumulation, and a result register toward the output stream.
// ----------------------------------------------------------------------------
module ddo_back #(
  parameter int FRAC_BITS    = ddo_pkg::FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [ddo_pkg::HT_W-1:0] half_turn_ticks,
  input  logic                   q_valid,
  output logic                   q_ready,
  input  ddo_pkg::cmd_item_t      q_item,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [47:0]            pos_x,
  output logic [47:0]            pos_y,
  output logic [31:0]            heading,
  output logic [31:0]            travelled,
  output logic [31:0]            dist_rate,
  output logic [31:0]            angular_speed
);

  localparam int SH    = 30 - FRAC_BITS;
  localparam int STEPS = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_CORDIC, S_MUL, S_ACC, S_OUT
  } state_t;

  state_t state;

  logic [47:0] x_accum;
  logic [47:0] y_accum;
  logic [31:0] heading_reg;
  logic [31:0] distance_reg;
  logic [31:0] heading_offset;
  logic [31:0] lin_reg;
  logic [31:0] ang_reg;

  logic [31:0] new_dist;
  logic [31:0] new_head;
  logic [31:0] d_dist;
  logic [31:0] d_head;
  logic [31:0] half;
  logic [31:0] mid;
  logic [20:0] period;

  logic        div_start;
  logic        div_done;
  logic [31:0] angle;

  logic signed [33:0] cx;
  logic signed [33:0] cy;
  logic signed [32:0] cz;
  logic [4:0]         step;
  logic               flip;
  logic signed [31:0] dd;
  logic signed [65:0] px;
  logic signed [65:0] py;

  logic signed [33:0] xs;
  logic signed [33:0] ys;
  logic [31:0]        at;

  assign new_dist = q_item.right_count + q_item.left_count;
  assign new_head = q_item.right_count - q_item.left_count + heading_offset;
  assign d_dist   = new_dist - distance_reg;
  assign d_head   = new_head - heading_reg;
  // truncating halve toward zero
  assign half     = {d_head[31], d_head[31:1]} + {31'd0, d_head[31] & d_head[0]};
  assign mid      = heading_reg + half;
  assign period   = (half_turn_ticks == '0) ? 21'd2 : {half_turn_ticks, 1'b0};

  assign xs = cx >>> step;
  assign ys = cy >>> step;
  assign at = ddo_pkg::atan_turn(step);

  assign q_ready = (state == S_IDLE) && !out_valid;

  ddo_divider u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .mid    (mid),
    .period (period),
    .done   (div_done),
    .angle  (angle)
  );

  assign div_start = (state == S_IDLE) && !out_valid && q_valid &&
                     (q_item.command == ddo_pkg::CMD_SAMPLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      x_accum        <= '0;
      y_accum        <= '0;
      heading_reg    <= '0;
      distance_reg   <= '0;
      heading_offset <= '0;
      lin_reg        <= '0;
      ang_reg        <= '0;
      step           <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid && !out_valid) begin
            case (q_item.command)
              ddo_pkg::CMD_SAMPLE: begin
                dd           <= d_dist;
                heading_reg  <= new_head;
                distance_reg <= new_dist;
                lin_reg      <= d_dist;
                ang_reg      <= d_head;
                state        <= S_DIV;
              end
              ddo_pkg::CMD_SET_X: begin
                x_accum <= q_item.set_value;
                state   <= S_OUT;
              end
              ddo_pkg::CMD_SET_Y: begin
                y_accum <= q_item.set_value;
                state   <= S_OUT;
              end
              ddo_pkg::CMD_SET_H: begin
                heading_offset <= heading_offset + q_item.set_value[31:0] - heading_reg;
                state          <= S_OUT;
              end
              default: state <= S_OUT;
            endcase
          end
        end
        S_DIV: begin
          if (div_done) begin
            // left half plane: turn by half a turn, negate afterwards;
            // after the turn the top bit always equals angle[30]
            flip  <= (angle[31:30] == 2'b01) || (angle[31:30] == 2'b10);
            cz    <= {angle[30], angle[30], angle[30:0]};
            cx    <= ddo_pkg::CORDIC_GAIN;
            cy    <= '0;
            step  <= '0;
            state <= S_CORDIC;
          end
        end
        S_CORDIC: begin
          if (!cz[32]) begin
            cx <= cx - ys;
            cy <= cy + xs;
            cz <= cz - $signed({1'b0, at});
          end else begin
            cx <= cx + ys;
            cy <= cy - xs;
            cz <= cz + $signed({1'b0, at});
          end
          step <= step + 5'd1;
          if (step == 5'(STEPS - 1)) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          px    <= dd * (flip ? -cx : cx);
          py    <= dd * (flip ? -cy : cy);
          state <= S_ACC;
        end
        S_ACC: begin
          x_accum <= x_accum + 48'((px + (66'sd1 <<< (SH - 1))) >>> SH);
          y_accum <= y_accum + 48'((py + (66'sd1 <<< (SH - 1))) >>> SH);
          state   <= S_OUT;
        end
        S_OUT: begin
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign pos_x         = x_accum;
  assign pos_y         = y_accum;
  assign heading       = heading_reg;
  assign travelled     = distance_reg;
  assign dist_rate     = lin_reg;
  assign angular_speed = ang_reg;

endmodule

>>> hw/rtl/ddo_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddo_props
// Port-level checks of the odometry unit.
// ----------------------------------------------------------------------------
module ddo_props (
  input logic         clk,
  input logic         rst,
  input logic         pready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [223:0] m_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat dropped or changed under stall");

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");

  a_gap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready |=> !m_tvalid)
    else $error("back-to-back result beats from one engine");

  a_reset: assert property (@(posedge clk) !rst && $past(rst) |-> !m_tvalid)
    else $error("result valid right after reset");

endmodule

bind differential_drive_odometry_unit ddo_props u_chk (
  .clk      (clk),
  .rst      (rst),
  .pready   (pready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
